/* rtl/plse_pkg.sv */
// Shared types, constants and the step table ROM of the LED sequence engine.
package plse_pkg;

  // Default sizes of the engine.
  localparam int NUM_LEDS_DEF  = 2;
  localparam int NUM_SEQS_DEF  = 9;
  localparam int MAX_STEPS_DEF = 16;
  localparam int WAIT_BITS_DEF = 11;

  // Fixed field widths on the streams.
  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 16;
  localparam int ACTIVE_W    = 4;
  localparam int ROM_MS_W    = 16;
  localparam int ROM_POS_W   = 7;

  // Command codes carried in tuser.
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2
  } cmd_t;

  // Kinds of a step in the ROM.
  typedef enum logic [1:0] {
    KIND_STOP = 2'd0,
    KIND_WAIT = 2'd1,
    KIND_LOOP = 2'd2
  } step_kind_t;

  typedef struct packed {
    logic                  level;
    step_kind_t            kind;
    logic [ROM_MS_W-1:0]   ms;
  } step_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_WALK,
    ST_DONE
  } state_t;

  // Step table lookup. Entries that are not listed read as a stop step.
  function automatic step_t plse_rom(input logic [3:0] seq, input logic [ROM_POS_W-1:0] pos);
    step_t st;
    st = '{level: 1'b0, kind: KIND_STOP, ms: '0};
    case (seq)
      4'd0: begin
        // Seven short blinks, then the sequence ends.
        if (pos < ROM_POS_W'(14)) begin
          st = '{level: ~pos[0], kind: KIND_WAIT, ms: ROM_MS_W'(50)};
        end
      end
      4'd1, 4'd2: begin
        case (pos)
          ROM_POS_W'(0): st = '{level: 1'b1, kind: KIND_WAIT, ms: ROM_MS_W'(1000)};
          ROM_POS_W'(1): st = '{level: 1'b0, kind: KIND_LOOP, ms: '0};
          default: ;
        endcase
      end
      4'd3: begin
        case (pos)
          ROM_POS_W'(0): st = '{level: 1'b1, kind: KIND_WAIT, ms: ROM_MS_W'(200)};
          ROM_POS_W'(1): st = '{level: 1'b0, kind: KIND_WAIT, ms: ROM_MS_W'(800)};
          ROM_POS_W'(2): st = '{level: 1'b0, kind: KIND_LOOP, ms: '0};
          default: ;
        endcase
      end
      4'd4: begin
        case (pos)
          ROM_POS_W'(0): st = '{level: 1'b1, kind: KIND_WAIT, ms: ROM_MS_W'(500)};
          ROM_POS_W'(1): st = '{level: 1'b0, kind: KIND_WAIT, ms: ROM_MS_W'(500)};
          ROM_POS_W'(2): st = '{level: 1'b0, kind: KIND_LOOP, ms: '0};
          default: ;
        endcase
      end
      4'd5: begin
        case (pos)
          ROM_POS_W'(0): st = '{level: 1'b1, kind: KIND_WAIT, ms: ROM_MS_W'(50)};
          ROM_POS_W'(1): st = '{level: 1'b0, kind: KIND_WAIT, ms: ROM_MS_W'(250)};
          ROM_POS_W'(2): st = '{level: 1'b0, kind: KIND_LOOP, ms: '0};
          default: ;
        endcase
      end
      4'd6: begin
        case (pos)
          ROM_POS_W'(0): st = '{level: 1'b1, kind: KIND_WAIT, ms: ROM_MS_W'(50)};
          ROM_POS_W'(1): st = '{level: 1'b0, kind: KIND_WAIT, ms: ROM_MS_W'(450)};
          ROM_POS_W'(2): st = '{level: 1'b0, kind: KIND_LOOP, ms: '0};
          default: ;
        endcase
      end
      4'd7: begin
        case (pos)
          ROM_POS_W'(0): st = '{level: 1'b1, kind: KIND_WAIT, ms: ROM_MS_W'(50)};
          ROM_POS_W'(1): st = '{level: 1'b0, kind: KIND_WAIT, ms: ROM_MS_W'(1950)};
          ROM_POS_W'(2): st = '{level: 1'b0, kind: KIND_LOOP, ms: '0};
          default: ;
        endcase
      end
      4'd8: begin
        case (pos)
          ROM_POS_W'(0): st = '{level: 1'b1, kind: KIND_WAIT, ms: ROM_MS_W'(10)};
          ROM_POS_W'(1): st = '{level: 1'b0, kind: KIND_WAIT, ms: ROM_MS_W'(10)};
          default: ;
        endcase
      end
      default: ;
    endcase
    return st;
  endfunction

endpackage

/* rtl/plse_first_run.sv */
// Priority encoder that finds the lowest-numbered running sequence of one LED.
module plse_first_run #(
  parameter int NUM_SEQS = plse_pkg::NUM_SEQS_DEF,
  parameter int AW       = 4
) (
  input  logic [NUM_SEQS-1:0] run_mask,
  output logic [AW-1:0]       first_idx
);
  import plse_pkg::*;

  // Scan from the lowest priority up so that the highest priority wins.
  always_comb begin
    first_idx = AW'(NUM_SEQS);
    for (int s = NUM_SEQS - 1; s >= 0; s--) begin
      if (run_mask[s]) begin
        first_idx = AW'(s);
      end
    end
  end

endmodule

/* rtl/priority_led_sequence_engine.sv */
// Top level of the priority LED sequence engine: sequencer, step walker and stream ports.
//
// Usage. Each input item carries a command: a one-millisecond tick, a start or a
// stop of one sequence on one LED. Every accepted item returns exactly one result
// item holding both LED drive levels and the active sequence of each LED (the
// value NUM_SEQS means that no sequence runs on that LED).
// Timing. The block works on one item at a time and is not ready meanwhile. A
// shared step walker handles one ROM step per cycle; a tick visits each LED in
// turn and walks each LED whose countdown expires. A valid stop walks its LED,
// and a valid start walks it when the started sequence becomes the active one.
// A walk ends at the first timed step or when no sequence is active, and never
// exceeds NUM_SEQS * (MAX_STEPS + 2) steps.
// Output. The result sits in an output register; the next item is accepted while
// it waits, and the block holds its finished result until the register is free.
// Reset. All sequences are stopped, no LED has an active sequence, both
// countdowns are idle and both LEDs are off. Reset is synchronous.
module priority_led_sequence_engine #(
  parameter int NUM_LEDS  = plse_pkg::NUM_LEDS_DEF,
  parameter int NUM_SEQS  = plse_pkg::NUM_SEQS_DEF,
  parameter int MAX_STEPS = plse_pkg::MAX_STEPS_DEF,
  parameter int WAIT_BITS = plse_pkg::WAIT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input stream.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [plse_pkg::IN_TDATA_W-1:0]  in_tdata,   // [3:0] seq_id
  input  logic [plse_pkg::IN_TUSER_W-1:0]  in_tuser,   // [1:0] command, [2] led_sel
  // Result stream.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [plse_pkg::OUT_TDATA_W-1:0] out_tdata   // [0] left_on, [1] right_on,
                                                       // [5:2] left_active, [9:6] right_active
);
  import plse_pkg::*;

  localparam int LW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int AW = $clog2(NUM_SEQS + 1);
  localparam int PW = $clog2(2 * MAX_STEPS);
  localparam int NE = NUM_LEDS * NUM_SEQS;
  localparam int IW = (NE > 1) ? $clog2(NE) : 1;
  localparam int WALK_LIMIT = NUM_SEQS * (MAX_STEPS + 2);
  localparam int GW = $clog2(WALK_LIMIT + 1);
  localparam logic [PW-1:0] POS_STOPPED = PW'(2 * MAX_STEPS - 1);
  localparam logic [LW-1:0] LED_LAST = LW'(NUM_LEDS - 1);

  // Sequencer and per-LED state.
  state_t                 state_r, state_nxt;
  logic [NUM_SEQS-1:0]    run_r [NUM_LEDS];
  logic [NUM_SEQS-1:0]    run_nxt [NUM_LEDS];
  logic [AW-1:0]          active_r [NUM_LEDS];
  logic [AW-1:0]          active_nxt [NUM_LEDS];
  logic [WAIT_BITS-1:0]   rem_r [NUM_LEDS];
  logic [WAIT_BITS-1:0]   rem_nxt [NUM_LEDS];
  logic                   level_r [NUM_LEDS];
  logic                   level_nxt [NUM_LEDS];
  logic [LW-1:0]          led_r, led_nxt;
  logic                   tick_mode_r, tick_mode_nxt;
  logic [GW-1:0]          guard_r, guard_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // Step position store, one entry per LED and sequence.
  logic [PW-1:0]          pos_r [NE];
  logic                   pos_we;
  logic [IW-1:0]          pos_waddr;
  logic [PW-1:0]          pos_wdata;

  // Input decode.
  logic                   in_acc;
  logic [1:0]             in_cmd;
  logic                   in_led;
  logic [3:0]             in_seq;
  logic                   cmd_ok;
  logic [LW-1:0]          sel_led;
  logic [IW-1:0]          wr_addr;
  logic [NUM_SEQS-1:0]    seq_bit;

  // Walker datapath.
  logic [AW-1:0]          act_cur;
  logic                   act_ok;
  logic [IW-1:0]          rd_addr;
  logic [PW-1:0]          pos_cur;
  logic [PW-1:0]          pos_inc;
  step_t                  entry;
  logic [WAIT_BITS-1:0]   entry_ms;
  logic                   guard_done;
  logic                   walk_halt;
  logic                   walk_end;
  logic                   done_free;
  logic [NUM_SEQS-1:0]    enc_in;
  logic [AW-1:0]          enc_out;
  logic                   right_on;
  logic [ACTIVE_W-1:0]    right_act;

  assign in_acc  = in_tvalid && in_tready;
  assign in_cmd  = in_tuser[1:0];
  assign in_led  = in_tuser[2];
  assign in_seq  = in_tdata[3:0];
  assign cmd_ok  = ((in_cmd == CMD_START) || (in_cmd == CMD_STOP)) &&
                   (int'(in_led) < NUM_LEDS) && (int'(in_seq) < NUM_SEQS);
  assign sel_led = LW'(in_led);
  assign wr_addr = IW'(int'(in_led) * NUM_SEQS + int'(in_seq));
  assign seq_bit = NUM_SEQS'(1) << in_seq;

  // Current step of the active sequence of the LED being walked.
  assign act_cur    = active_r[led_r];
  assign act_ok     = int'(act_cur) < NUM_SEQS;
  assign rd_addr    = IW'(int'(led_r) * NUM_SEQS + int'(act_cur));
  assign pos_cur    = pos_r[rd_addr];
  assign pos_inc    = (int'(pos_cur) >= MAX_STEPS) ? PW'(MAX_STEPS) : pos_cur + PW'(1);
  assign entry      = (int'(pos_cur) < MAX_STEPS) ?
                      plse_rom(4'(act_cur), ROM_POS_W'(pos_cur)) :
                      '{level: 1'b0, kind: KIND_STOP, ms: '0};
  assign entry_ms   = WAIT_BITS'(entry.ms);
  assign guard_done = (guard_r == GW'(WALK_LIMIT));
  assign walk_halt  = !act_ok || guard_done;
  assign walk_end   = walk_halt || ((entry.kind == KIND_WAIT) && (entry_ms != '0));
  assign done_free  = !out_valid_r || out_tready;

  // Running mask after the pending change, fed to the shared priority encoder.
  always_comb begin
    if (state_r == ST_IDLE) begin
      if (in_cmd == CMD_START) begin
        enc_in = run_r[sel_led] | seq_bit;
      end else begin
        enc_in = run_r[sel_led] & ~seq_bit;
      end
    end else begin
      enc_in = run_r[led_r] & ~(NUM_SEQS'(1) << act_cur);
    end
  end

  plse_first_run #(
    .NUM_SEQS (NUM_SEQS),
    .AW       (AW)
  ) u_first_run (
    .run_mask  (enc_in),
    .first_idx (enc_out)
  );

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_cmd == CMD_TICK) begin
            state_nxt = ST_TICK;
          end else if (!cmd_ok) begin
            state_nxt = ST_DONE;
          end else if (in_cmd == CMD_STOP) begin
            state_nxt = ST_WALK;
          end else if (int'(enc_out) == int'(in_seq)) begin
            state_nxt = ST_WALK;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_TICK: begin
        if (rem_r[led_r] == WAIT_BITS'(1)) begin
          state_nxt = ST_WALK;
        end else if (led_r == LED_LAST) begin
          state_nxt = ST_DONE;
        end
      end
      ST_WALK: begin
        if (walk_end) begin
          if (tick_mode_r && (led_r != LED_LAST)) begin
            state_nxt = ST_TICK;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (done_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake outputs of the sequencer.
  always_comb begin
    in_tready = (state_r == ST_IDLE);
  end

  // Per-LED state updates and step position writes.
  always_comb begin
    run_nxt       = run_r;
    active_nxt    = active_r;
    rem_nxt       = rem_r;
    level_nxt     = level_r;
    led_nxt       = led_r;
    tick_mode_nxt = tick_mode_r;
    guard_nxt     = guard_r;
    pos_we        = 1'b0;
    pos_waddr     = rd_addr;
    pos_wdata     = pos_inc;
    case (state_r)
      ST_IDLE: begin
        guard_nxt = '0;
        if (in_acc) begin
          if (in_cmd == CMD_TICK) begin
            tick_mode_nxt = 1'b1;
            led_nxt       = '0;
          end else begin
            tick_mode_nxt = 1'b0;
            led_nxt       = sel_led;
            if (cmd_ok) begin
              pos_we               = 1'b1;
              pos_waddr            = wr_addr;
              pos_wdata            = (in_cmd == CMD_START) ? '0 : POS_STOPPED;
              run_nxt[sel_led]     = enc_in;
              active_nxt[sel_led]  = enc_out;
              level_nxt[sel_led]   = 1'b0;
            end
          end
        end
      end
      ST_TICK: begin
        guard_nxt = '0;
        if (rem_r[led_r] != '0) begin
          rem_nxt[led_r] = rem_r[led_r] - WAIT_BITS'(1);
        end
        if ((rem_r[led_r] != WAIT_BITS'(1)) && (led_r != LED_LAST)) begin
          led_nxt = led_r + LW'(1);
        end
      end
      ST_WALK: begin
        // One ROM step of the active sequence per cycle.
        if (!walk_halt) begin
          guard_nxt = guard_r + GW'(1);
          pos_we    = 1'b1;
          case (entry.kind)
            KIND_LOOP: begin
              pos_wdata = '0;
            end
            KIND_WAIT: begin
              pos_wdata        = pos_inc;
              level_nxt[led_r] = entry.level;
              if (entry_ms != '0) begin
                rem_nxt[led_r] = entry_ms;
              end
            end
            default: begin
              pos_wdata         = POS_STOPPED;
              run_nxt[led_r]    = enc_in;
              active_nxt[led_r] = enc_out;
              level_nxt[led_r]  = 1'b0;
            end
          endcase
        end
        if (walk_end && tick_mode_r && (led_r != LED_LAST)) begin
          led_nxt = led_r + LW'(1);
        end
      end
      default: ;
    endcase
  end

  // Right LED fields read as off and none running when that LED does not exist.
  if (NUM_LEDS > 1) begin : g_right
    assign right_on  = level_r[1];
    assign right_act = ACTIVE_W'(active_r[1]);
  end else begin : g_no_right
    assign right_on  = 1'b0;
    assign right_act = ACTIVE_W'(NUM_SEQS);
  end

  // Output register load.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if ((state_r == ST_DONE) && done_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {(OUT_TDATA_W - 2 - 2 * ACTIVE_W)'(0), right_act,
                       ACTIVE_W'(active_r[0]), right_on, level_r[0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int l = 0; l < NUM_LEDS; l++) begin
        run_r[l]    <= '0;
        active_r[l] <= AW'(NUM_SEQS);
        rem_r[l]    <= '0;
        level_r[l]  <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      run_r       <= run_nxt;
      active_r    <= active_nxt;
      rem_r       <= rem_nxt;
      level_r     <= level_nxt;
    end
  end

  // Working registers and the output payload.
  always_ff @(posedge clk) begin
    led_r       <= led_nxt;
    tick_mode_r <= tick_mode_nxt;
    guard_r     <= guard_nxt;
    out_data_r  <= out_data_nxt;
  end

  // Step position store; only entries of running sequences are ever used.
  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_r[pos_waddr] <= pos_wdata;
    end
  end

`ifndef ASSERT_OFF
  // A walk never runs past its step bound.
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (int'(guard_r) <= WALK_LIMIT))
    else $error("step walk exceeded its bound");

  // Between items, the active sequence of LED 0 is a running one.
  a_active_runs: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_IDLE) && (int'(active_r[0]) < NUM_SEQS)) |->
    (((run_r[0] >> active_r[0]) & NUM_SEQS'(1)) != '0))
    else $error("active sequence is not running");

  // With nothing running, LED 0 reports no active sequence.
  a_none_active: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_IDLE) && (run_r[0] == '0)) |-> (active_r[0] == AW'(NUM_SEQS)))
    else $error("active sequence set with nothing running");

  // A finished item reaches the output register in the next cycle.
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DONE) && done_free) |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("finished item not delivered to the output register");
`endif

endmodule

/* verif/priority_led_sequence_engine_tb.sv */
// Self-checking testbench for the priority LED sequence engine with a stream driver and monitor.
`timescale 1ns / 100ps

module priority_led_sequence_engine_tb;
  import plse_pkg::*;

  localparam int LEDS       = 2;
  localparam int SEQS       = 9;
  localparam int STEPS      = 16;
  localparam int WAIT_W     = 11;
  localparam int POS_HALT   = 2 * STEPS - 1;
  localparam int WALK_MAX   = SEQS * (STEPS + 2);
  localparam int ITEM_GOAL  = 1150;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // One pending input item, with a flag that holds it back until all results are in.
  typedef struct {
    logic [1:0] cmd;
    logic       led;
    logic [3:0] seq;
    bit         drain;
  } led_cmd_t;

  // Fields of one result item.
  typedef struct {
    logic       left_on;
    logic       right_on;
    logic [3:0] left_active;
    logic [3:0] right_active;
  } led_status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;   // [3:0] seq_id
  logic [IN_TUSER_W-1:0] in_tuser = '0;   // [1:0] command, [2] led_sel
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;      // [0] left_on, [1] right_on,
                                          // [5:2] left_active, [9:6] right_active

  led_cmd_t    command_q[$];
  led_status_t led_status_q[$];
  bit          in_taken = 1'b0;
  int          send_gap = 0;
  int          hold_left = 0;
  bit          send_calm = 1'b0;
  bit          recv_calm = 1'b0;
  int          items_total = 0;
  int          items_accepted = 0;
  int          mismatch_count = 0;

  // Predicted engine state.
  logic [4:0]        seq_pos[LEDS][SEQS];
  logic [3:0]        led_active[LEDS];
  logic [WAIT_W-1:0] ms_left[LEDS];
  logic              led_on[LEDS];

  priority_led_sequence_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Step tables: each sequence is an on/off pattern followed by a loop or an end.
  function automatic step_t blink_step(input int seq, input int pos);
    step_t st;
    int on_ms;
    int off_ms;
    st = '{level: 1'b0, kind: KIND_STOP, ms: '0};
    on_ms = 50;
    off_ms = 50;
    case (seq)
      0: begin
        if (pos < 14) begin
          st = '{level: (pos % 2 == 0), kind: KIND_WAIT, ms: 16'd50};
        end
      end
      1, 2: begin
        if (pos == 0) begin
          st = '{level: 1'b1, kind: KIND_WAIT, ms: 16'd1000};
        end else if (pos == 1) begin
          st = '{level: 1'b0, kind: KIND_LOOP, ms: '0};
        end
      end
      3, 4, 5, 6, 7, 8: begin
        case (seq)
          3: begin on_ms = 200; off_ms = 800; end
          4: begin on_ms = 500; off_ms = 500; end
          5: off_ms = 250;
          6: off_ms = 450;
          7: off_ms = 1950;
          default: begin on_ms = 10; off_ms = 10; end
        endcase
        if (pos == 0) begin
          st = '{level: 1'b1, kind: KIND_WAIT, ms: 16'(on_ms)};
        end else if (pos == 1) begin
          st = '{level: 1'b0, kind: KIND_WAIT, ms: 16'(off_ms)};
        end else if (pos == 2 && seq != 8) begin
          st = '{level: 1'b0, kind: KIND_LOOP, ms: '0};
        end
      end
      default: ;
    endcase
    return st;
  endfunction

  // Pick the highest-priority running sequence; any recompute turns the LED off.
  task automatic refresh_active(input int l);
    bit found;
    found = 1'b0;
    led_active[l] = 4'(SEQS);
    led_on[l] = 1'b0;
    for (int s = 0; s < SEQS; s++) begin
      if (!found && seq_pos[l][s] != 5'(POS_HALT)) begin
        led_active[l] = 4'(s);
        found = 1'b1;
      end
    end
  endtask

  // Advance the active sequence until a timed step loads the countdown.
  task automatic walk_led(input int l);
    int a;
    int pos;
    bit done;
    step_t st;
    done = 1'b0;
    for (int guard = 0; guard < WALK_MAX && !done; guard++) begin
      a = led_active[l];
      if (a >= SEQS) begin
        done = 1'b1;
      end else begin
        pos = seq_pos[l][a];
        st = blink_step(a, pos);
        seq_pos[l][a] = 5'((pos + 1 > STEPS) ? STEPS : pos + 1);
        case (st.kind)
          KIND_LOOP: seq_pos[l][a] = '0;
          KIND_WAIT: begin
            led_on[l] = st.level;
            if (st.ms[WAIT_W-1:0] != '0) begin
              ms_left[l] = st.ms[WAIT_W-1:0];
              done = 1'b1;
            end
          end
          default: begin
            seq_pos[l][a] = 5'(POS_HALT);
            refresh_active(l);
          end
        endcase
      end
    end
  endtask

  // Apply one accepted item to the predicted state and return the LED status it yields.
  task automatic predict_led_status(input logic [1:0] cmd, input logic led,
                                    input logic [3:0] seq, output led_status_t st);
    int l;
    l = led;
    if (cmd == CMD_TICK) begin
      for (int k = 0; k < LEDS; k++) begin
        if (ms_left[k] != '0) begin
          ms_left[k]--;
          if (ms_left[k] == '0) begin
            walk_led(k);
          end
        end
      end
    end else if ((cmd == CMD_START || cmd == CMD_STOP) && seq < SEQS) begin
      if (cmd == CMD_START) begin
        seq_pos[l][seq] = '0;
        refresh_active(l);
        if (led_active[l] == seq) begin
          walk_led(l);
        end
      end else begin
        seq_pos[l][seq] = 5'(POS_HALT);
        refresh_active(l);
        walk_led(l);
      end
    end
    st.left_on      = led_on[0];
    st.right_on     = led_on[1];
    st.left_active  = led_active[0];
    st.right_active = led_active[1];
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Mostly short gaps, a few long ones, none at all during a calm stretch.
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic add_item(input logic [1:0] cmd, input logic led, input logic [3:0] seq,
                          input bit drain);
    led_cmd_t it;
    it.cmd = cmd;
    it.led = led;
    it.seq = seq;
    it.drain = drain;
    command_q.push_back(it);
  endtask

  // Input driver: presents the next queued item once the previous one was taken.
  always @(negedge clk) begin : driver
    led_cmd_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (command_q.size() > 0 &&
                   !(command_q[0].drain && led_status_q.size() != 0)) begin
        it = command_q.pop_front();
        in_tuser <= {it.led, it.cmd};
        in_tdata <= {4'b0000, it.seq};
        in_tvalid <= 1'b1;
        send_gap = pick_gap(send_calm);
        if ($urandom_range(0, 99) < 3) send_calm = !send_calm;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls on the ready line.
  always @(negedge clk) begin : receiver
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      hold_left = pick_gap(recv_calm);
      if ($urandom_range(0, 99) < 3) recv_calm = !recv_calm;
    end
  end

  // Monitor: checks each result against the oldest prediction, predicts each accepted item.
  always @(posedge clk) begin : monitor
    led_status_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (led_status_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with no item pending, expected none, got 0x%0h",
                   $time, out_tdata);
        end else begin
          want = led_status_q.pop_front();
          check_field("left_on", want.left_on, out_tdata[0]);
          check_field("right_on", want.right_on, out_tdata[1]);
          check_field("left_active", want.left_active, out_tdata[5:2]);
          check_field("right_active", want.right_active, out_tdata[9:6]);
        end
      end
      if (in_tvalid && in_tready) begin
        predict_led_status(in_tuser[1:0], in_tuser[2], in_tdata[3:0], want);
        led_status_q.push_back(want);
        items_accepted++;
      end
    end
    in_taken <= rst_n && in_tvalid && in_tready;
  end

  initial begin : stimulus
    int r;
    int n;
    int burst;
    bit drain;
    logic [1:0] cmd;
    logic [3:0] seq;

    // Predicted state after reset.
    for (int l = 0; l < LEDS; l++) begin
      for (int s = 0; s < SEQS; s++) seq_pos[l][s] = 5'(POS_HALT);
      led_active[l] = 4'(SEQS);
      ms_left[l] = '0;
      led_on[l] = 1'b0;
    end

    // Directed: ignored items, priority preemption, restart, stop and sequence end.
    add_item(CMD_TICK, 1'b0, 4'd0, 1'b0);
    add_item(CMD_UNUSED, 1'b1, 4'd15, 1'b0);
    add_item(CMD_START, 1'b0, 4'd9, 1'b0);
    add_item(CMD_START, 1'b1, 4'd15, 1'b0);
    add_item(CMD_STOP, 1'b0, 4'd15, 1'b0);
    add_item(CMD_STOP, 1'b0, 4'd3, 1'b0);
    add_item(CMD_START, 1'b0, 4'd8, 1'b0);
    add_item(CMD_START, 1'b1, 4'd7, 1'b0);
    add_item(CMD_START, 1'b0, 4'd0, 1'b0);
    // A lower-priority start only blanks the LED.
    add_item(CMD_START, 1'b0, 4'd5, 1'b0);
    add_item(CMD_START, 1'b0, 4'd0, 1'b0);
    add_item(CMD_STOP, 1'b0, 4'd0, 1'b0);
    add_item(CMD_STOP, 1'b0, 4'd5, 1'b0);
    // Let the short sequence run to its end step.
    repeat (10) add_item(CMD_TICK, 1'b1, 4'd8, 1'b0);
    // Stopping the only sequence leaves a stale countdown behind.
    add_item(CMD_STOP, 1'b1, 4'd7, 1'b0);
    add_item(CMD_START, 1'b1, 4'd1, 1'b0);

    // Random: clusters of commands followed by bursts of ticks.
    drain = 1'b1;
    while (command_q.size() < ITEM_GOAL) begin
      n = $urandom_range(1, 3);
      drain = drain || ($urandom_range(0, 49) == 0);
      repeat (n) begin
        r = $urandom_range(0, 99);
        cmd = (r < 60) ? CMD_START : (r < 92) ? CMD_STOP : (r < 96) ? CMD_UNUSED : CMD_TICK;
        seq = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                          : 4'($urandom_range(0, 8));
        add_item(cmd, 1'($urandom_range(0, 1)), seq, drain);
        drain = 1'b0;
      end
      r = $urandom_range(0, 99);
      burst = (r < 75) ? $urandom_range(0, 15) :
              (r < 97) ? $urandom_range(15, 80) : $urandom_range(200, 720);
      // Keep the total close to the item goal.
      if (command_q.size() + burst > ITEM_GOAL) begin
        burst = (command_q.size() < ITEM_GOAL) ? ITEM_GOAL - command_q.size() : 0;
      end
      repeat (burst) add_item(CMD_TICK, 1'($urandom_range(0, 1)),
                              4'($urandom_range(0, 15)), 1'b0);
    end
    items_total = command_q.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (items_accepted == items_total);
    wait (led_status_q.size() == 0);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #15_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

/* files.f */
rtl/plse_pkg.sv
rtl/plse_first_run.sv
rtl/priority_led_sequence_engine.sv
verif/priority_led_sequence_engine_tb.sv
